@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the filter RTL.
// Each macro expects signals named clk and rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fir_sat_pkg.sv @@
// Shared types and constants for the saturating FIR filter.
// No dependencies; used by fir_sat_mac and fir_filter_saturating_unit.
package fir_sat_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int INDEX_W  = 8;
  localparam int OP_W     = 2;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int FRAC_W   = 14;

  // Operation carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_FILTER = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // Sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic issue;  // a tap read was issued this cycle
    logic live;   // that tap holds a real sample
  } mac_ctrl_t;

endpackage

@@ rtl/core/fir_sat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fir_sat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 129
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fir_sat_mac.sv @@
// Shared multiply-accumulate unit with final round and saturate.
// Depends on fir_sat_pkg for widths and the control struct.
module fir_sat_mac #(
  parameter int TAPS = 129
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fir_sat_pkg::mac_ctrl_t              ctrl,
  input  logic [fir_sat_pkg::SAMPLE_W-1:0]    hist_data,
  input  logic [fir_sat_pkg::COEF_W-1:0]      coef_data,
  output logic                                busy,
  output logic [fir_sat_pkg::SAMPLE_W-1:0]    sample_out,
  output logic                                saturated
);

  localparam int ACC_W = fir_sat_pkg::PROD_W + 1 + $clog2(TAPS);
  localparam logic signed [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << (fir_sat_pkg::FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN   = ACC_W'(-32768);

  logic                                   issue_d;
  logic                                   live_d;
  logic                                   prod_valid;
  logic signed [fir_sat_pkg::PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]                acc;
  logic signed [ACC_W-1:0]                rounded;
  logic signed [ACC_W-1:0]                shifted;

  // Align flags with RAM read data, multiply, then accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_d    <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      issue_d    <= ctrl.issue;
      prod_valid <= issue_d;
    end
    live_d <= ctrl.live;
    if (live_d) begin
      prod <= $signed(hist_data) * $signed(coef_data);
    end else begin
      prod <= '0;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign busy = issue_d | prod_valid;

  // Round to nearest (ties up), then clamp to 16 bits
  assign rounded = acc + ROUND_ADD;
  assign shifted = rounded >>> fir_sat_pkg::FRAC_W;

  always_comb begin
    if (shifted > SAT_MAX) begin
      sample_out = SAT_MAX[fir_sat_pkg::SAMPLE_W-1:0];
      saturated  = 1'b1;
    end else if (shifted < SAT_MIN) begin
      sample_out = SAT_MIN[fir_sat_pkg::SAMPLE_W-1:0];
      saturated  = 1'b1;
    end else begin
      sample_out = shifted[fir_sat_pkg::SAMPLE_W-1:0];
      saturated  = 1'b0;
    end
  end

endmodule

@@ rtl/core/fir_filter_saturating_unit.sv @@
// Saturating FIR filter: streaming input and output, one shared MAC unit.
//
// Input words (s_*) carry an operation in s_tuser: filter a sample, write
// one coefficient, or clear the sample history. Only a filter word gives an
// output word (m_*): the rounded, 16-bit saturated sum of history times
// coefficients, with m_tuser set when the sum was clamped.
// A filter word runs one tap per cycle through the shared multiply-accumulate
// unit, then drains through the RAM read, product and final accumulate stages
// before the output register is loaded. The next input word is taken only
// after that load, a limit set by the single MAC and the single history read port.
// Coefficient writes and clears complete without leaving the idle state.
// s_tready is high only while the sequencer is idle; an input word may be
// accepted while a finished output word still waits in the output register.
// If the receiver stalls, the next result is held until that register frees.
// Reset empties the history (a fill count masks stale entries, no clearing
// pass) and drops any pending output; coefficients are undefined until
// written, and reading an unwritten one gives an undefined output.
// Depends on fir_sat_pkg, fir_sat_ram, fir_sat_mac and assert_macros.svh.
`include "assert_macros.svh"

module fir_filter_saturating_unit #(
  parameter int TAPS = 129
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] sample_in, [23:16] coef_index, [41:24] coef_value, [47:42] zero
  input  logic [47:0] s_tdata,
  // [1:0] operation
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] sample_out
  output logic [15:0] m_tdata,
  // [0] saturated
  output logic [0:0]  m_tuser
);

  localparam int AW = $clog2(TAPS);
  localparam int CW = $clog2(TAPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t                                state;
  logic [AW-1:0]                         head;
  logic [AW-1:0]                         head_next;
  logic [CW-1:0]                         fill;
  logic [AW-1:0]                         tap;
  logic [AW-1:0]                         rd_addr;
  logic                                  s_acc;
  fir_sat_pkg::op_t                      op;
  logic [fir_sat_pkg::SAMPLE_W-1:0]      sample_in;
  logic [fir_sat_pkg::INDEX_W-1:0]       coef_index;
  logic [fir_sat_pkg::COEF_W-1:0]        coef_value;
  logic                                  idx_ok;
  logic [fir_sat_pkg::SAMPLE_W-1:0]      hist_data;
  logic [fir_sat_pkg::COEF_W-1:0]        coef_data;
  fir_sat_pkg::mac_ctrl_t                ctrl;
  logic                                  busy;
  logic [fir_sat_pkg::SAMPLE_W-1:0]      res_sample;
  logic                                  res_sat;
  logic                                  out_load;

  // Unpack the input word
  assign s_tready   = (state == ST_IDLE);
  assign s_acc      = s_tvalid & s_tready;
  assign op         = fir_sat_pkg::op_t'(s_tuser);
  assign sample_in  = s_tdata[15:0];
  assign coef_index = s_tdata[23:16];
  assign coef_value = s_tdata[41:24];
  assign idx_ok     = (32'(coef_index) < TAPS);

  // Circular history: head points at the newest sample
  assign head_next = (head == AW'(TAPS - 1)) ? '0 : head + 1'b1;

  fir_sat_ram #(
    .WIDTH (fir_sat_pkg::SAMPLE_W),
    .DEPTH (TAPS)
  ) u_hist (
    .clk   (clk),
    .we    (s_acc && op == fir_sat_pkg::OP_FILTER),
    .waddr (head_next),
    .wdata (sample_in),
    .raddr (rd_addr),
    .rdata (hist_data)
  );

  fir_sat_ram #(
    .WIDTH (fir_sat_pkg::COEF_W),
    .DEPTH (TAPS)
  ) u_coef (
    .clk   (clk),
    .we    (s_acc && op == fir_sat_pkg::OP_WRITE && idx_ok),
    .waddr (AW'(coef_index)),
    .wdata (coef_value),
    .raddr (tap),
    .rdata (coef_data)
  );

  // Taps older than the fill count read as zero
  assign ctrl.clear = s_acc && op == fir_sat_pkg::OP_FILTER;
  assign ctrl.issue = (state == ST_RUN);
  assign ctrl.live  = (CW'(tap) < fill);

  fir_sat_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .hist_data  (hist_data),
    .coef_data  (coef_data),
    .busy       (busy),
    .sample_out (res_sample),
    .saturated  (res_sat)
  );

  // Load the output register once the MAC pipe has drained and the slot is free
  assign out_load = (state == ST_DRAIN) && !busy && (!m_tvalid || m_tready);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      fill     <= '0;
      tap      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= res_sample;
        m_tuser[0] <= res_sat;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            case (op)
              fir_sat_pkg::OP_FILTER: begin
                head    <= head_next;
                rd_addr <= head_next;
                tap     <= '0;
                if (fill != CW'(TAPS)) begin
                  fill <= fill + 1'b1;
                end
                state <= ST_RUN;
              end
              fir_sat_pkg::OP_CLEAR: begin
                fill <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          tap     <= tap + 1'b1;
          rd_addr <= (rd_addr == '0) ? AW'(TAPS - 1) : rd_addr - 1'b1;
          if (tap == AW'(TAPS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_fill_range, fill <= CW'(TAPS), "fill count beyond TAPS")
  `ASSERT_IMPLIES(a_tap_range, state == ST_RUN, 32'(tap) < TAPS, "tap index out of range")
  `ASSERT_NEXT(a_start_run, s_acc && op == fir_sat_pkg::OP_FILTER,
               state == ST_RUN && tap == '0 && fill != '0, "sample did not start a run")
  `ASSERT_IMPLIES(a_out_from_drain, $rose(m_tvalid), $past(state == ST_DRAIN), "output not from drain")

endmodule

@@ sim/tb_fir_filter_saturating_unit.sv @@
// Self-checking testbench for fir_filter_saturating_unit: streams filter, coefficient
// write and history clear words, predicts every output word and compares it.
// Depends on fir_sat_pkg and the RTL of fir_filter_saturating_unit.
module tb_fir_filter_saturating_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS           = 129;
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_WORDS   = 640;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One input word as the filter sees it
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] smp;
    logic [7:0]  idx;
    logic [17:0] cval;
  } word_t;

  // One output word
  typedef struct packed {
    logic [15:0] level;
    logic        clipped;
  } filt_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  word_t     pending_words[$];
  filt_out_t expected_outputs[$];
  word_t     next_word;
  filt_out_t got_word;

  // Predictor state: newest sample at index 0
  logic signed [15:0] sample_hist [TAPS];
  logic signed [17:0] coef_table  [TAPS];

  logic in_fire = 1'b0;
  bit   src_idle_on  = 1'b1;
  bit   sink_idle_on = 1'b1;
  int   src_gap = 0;
  int   sink_stall = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   quiet_cycles = 0;
  int   mismatch_count = 0;
  int   words_issued = 0;
  int   n_samples = 0;
  int   n_clipped = 0;
  int   n_writes = 0;
  int   n_clears = 0;

  fir_filter_saturating_unit #(.TAPS(TAPS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(input bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 25);
    return $urandom_range(100, 400);
  endfunction

  // Queue one word; each field is cut to its width here
  task automatic push_word(input int op, input int smp, input int idx, input int cval);
    word_t w;
    w.op   = 2'(op);
    w.smp  = 16'(smp);
    w.idx  = 8'(idx);
    w.cval = 18'(cval);
    pending_words.push_back(w);
    words_issued++;
  endtask

  // Wait until every word is taken and every output word has come back
  task automatic drain_all();
    while (pending_words.size() != 0 || s_tvalid || expected_outputs.size() != 0)
      @(posedge clk);
  endtask

  // Update the filter state for one accepted word; a filter word also queues its output
  function automatic void apply_filter_word(input word_t w);
    longint    acc;
    longint    rounded;
    filt_out_t res;
    acc = 0;
    case (w.op)
      fir_sat_pkg::OP_WRITE: begin
        if (w.idx < TAPS) coef_table[w.idx] = w.cval;
        n_writes++;
      end
      fir_sat_pkg::OP_CLEAR: begin
        for (int m = 0; m < TAPS; m++) sample_hist[m] = '0;
        n_clears++;
      end
      fir_sat_pkg::OP_FILTER: begin
        for (int m = TAPS - 1; m > 0; m--) sample_hist[m] = sample_hist[m-1];
        sample_hist[0] = w.smp;
        for (int m = 0; m < TAPS; m++)
          acc += longint'(sample_hist[m]) * longint'(coef_table[m]);
        // round half up, then clamp to 16 bits
        rounded = (acc + 64'sd8192) >>> 14;
        res.clipped = 1'b1;
        if (rounded > 32767) rounded = 32767;
        else if (rounded < -32768) rounded = -32768;
        else res.clipped = 1'b0;
        res.level = rounded[15:0];
        expected_outputs.push_back(res);
        n_samples++;
        if (res.clipped) n_clipped++;
      end
      default: ;
    endcase
  endfunction

  // Drive input words at the falling edge; hold a word until it is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_fire) begin
    end else if (src_gap > 0) begin
      src_gap  <= src_gap - 1;
      s_tvalid <= 1'b0;
    end else if (pending_words.size() != 0) begin
      next_word = pending_words.pop_front();
      s_tdata  <= {6'b0, next_word.cval, next_word.idx, next_word.smp};
      s_tuser  <= next_word.op;
      s_tvalid <= 1'b1;
      src_gap  <= pick_gap(src_idle_on);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Drive output ready: random stalls plus the long hold on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_served < hold_requests) begin
      holds_served <= holds_served + 1;
      sink_stall   <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (sink_idle_on && $urandom_range(0, 9) == 0) sink_stall <= pick_gap(1'b1);
    end
  end

  // Predict on accepted inputs, check accepted outputs, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        apply_filter_word({s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[41:24]});
      if (m_tvalid && m_tready) begin
        if (expected_outputs.size() == 0) begin
          $error("unexpected output word: sample_out=%0d saturated=%0d",
                 $signed(m_tdata), m_tuser[0]);
          mismatch_count++;
        end else begin
          got_word = expected_outputs.pop_front();
          if (m_tdata !== got_word.level) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(got_word.level), $signed(m_tdata));
            mismatch_count++;
          end
          if (m_tuser[0] !== got_word.clipped) begin
            $error("saturated: expected %0d, got %0d", got_word.clipped, m_tuser[0]);
            mismatch_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else if (pending_words.size() != 0 || s_tvalid || expected_outputs.size() != 0)
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fir_filter_saturating_unit regression: fail");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int style;
    int v;
    int seg;
    logic [31:0] rnd;
    int idx;
    int cval;
    int smp;

    for (int m = 0; m < TAPS; m++) begin
      sample_hist[m] = '0;
      coef_table[m]  = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load the whole table: unit gain on the newest tap only
    for (int m = 0; m < TAPS; m++)
      push_word(fir_sat_pkg::OP_WRITE, $urandom(), m, (m == 0) ? 16384 : 0);

    // Pass-through of the sample extremes
    push_word(fir_sat_pkg::OP_FILTER, 16'sd32767, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, -16'sd32768, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, 16'sd0, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, 16'sd1, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, -16'sd1, $urandom(), $urandom());
    // Half gain: ties round toward positive infinity
    push_word(fir_sat_pkg::OP_WRITE, $urandom(), 8'd0, 8192);
    push_word(fir_sat_pkg::OP_FILTER, 16'sd1, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, -16'sd1, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, 16'sd3, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, -16'sd3, $urandom(), $urandom());
    // Largest positive and negative gain drive both clamps
    push_word(fir_sat_pkg::OP_WRITE, $urandom(), 8'd0, 131071);
    push_word(fir_sat_pkg::OP_FILTER, 16'sd32767, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, -16'sd32768, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_WRITE, $urandom(), 8'd0, -131072);
    push_word(fir_sat_pkg::OP_FILTER, -16'sd32768, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, 16'sd32767, $urandom(), $urandom());
    // Out-of-range taps are dropped; the last tap is writable
    push_word(fir_sat_pkg::OP_WRITE, $urandom(), 8'd129, 5);
    push_word(fir_sat_pkg::OP_WRITE, $urandom(), 8'd255, -1);
    push_word(fir_sat_pkg::OP_WRITE, $urandom(), 8'd128, 16384);
    push_word(OP_UNUSED, $urandom(), $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, 16'sd100, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_FILTER, -16'sd5, $urandom(), $urandom());
    push_word(fir_sat_pkg::OP_WRITE, $urandom(), 8'd0, 16384);
    push_word(fir_sat_pkg::OP_FILTER, 16'sd12345, $urandom(), $urandom());
    drain_all();

    // Random segments: retune some taps, then stream samples
    seg = 0;
    v = words_issued;
    while (words_issued < v + RANDOM_WORDS) begin
      src_idle_on  = $urandom_range(0, 3) != 0;
      sink_idle_on = $urandom_range(0, 3) != 0;
      style = $urandom_range(0, 3);
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(0, 19) == 0) idx = $urandom_range(TAPS, 255);
        else idx = $urandom_range(0, TAPS - 1);
        rnd = $urandom();
        case (style)
          0: cval = $urandom_range(0, 4095) - 2048;
          1: cval = $urandom_range(0, 32767) - 16384;
          2: cval = rnd[17:0];
          default: cval = rnd[0] ? 0 : (rnd[1] ? 16384 : -16384);
        endcase
        push_word(fir_sat_pkg::OP_WRITE, $urandom(), idx, cval);
      end
      // Let the receiver hold off while samples keep coming
      if (seg == 4) hold_requests++;
      repeat ($urandom_range(16, 48)) begin
        style = $urandom_range(0, 99);
        rnd = $urandom();
        if (style < 2) push_word(fir_sat_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
        else if (style < 4) push_word(OP_UNUSED, $urandom(), $urandom(), $urandom());
        else begin
          if (style < 60) smp = rnd[15:0];
          else if (style < 92) smp = $urandom_range(0, 512) - 256;
          else smp = rnd[0] ? 16'h7fff : 16'h8000;
          push_word(fir_sat_pkg::OP_FILTER, smp, $urandom(), $urandom());
        end
      end
      // Pause the sender until all outputs are back
      if (seg == 8) drain_all();
      seg++;
    end

    drain_all();
    repeat (2 * TAPS) @(posedge clk);
    $display("run covered %0d filtered samples (%0d clamped), %0d coefficient writes, %0d clears",
             n_samples, n_clipped, n_writes, n_clears);
    if (mismatch_count == 0) begin
      $display("fir_filter_saturating_unit regression: pass");
    end else begin
      $display("fir_filter_saturating_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fir_sat_pkg.sv
rtl/core/fir_sat_ram.sv
rtl/core/fir_sat_mac.sv
rtl/core/fir_filter_saturating_unit.sv
sim/tb_fir_filter_saturating_unit.sv
